/* rtl/mwuf_pkg.sv */
// ----------------------------------------------------------------------------
// mwuf_pkg
// Shared constants, types and helpers for the maze wall union-find filter.
// ----------------------------------------------------------------------------
package mwuf_pkg;

    // Grid limits
    localparam int MAX_SIDE  = 32;
    localparam int MAX_CELLS = 1024;

    // Field and storage widths
    localparam int SIDE_W    = 6;
    localparam int COORD_W   = 5;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int PROD_W    = (2 * SIDE_W > CNT_W) ? 2 * SIDE_W : CNT_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [SIDE_W-1:0]  t_side;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CELL_W-1:0]  t_cell;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx REG_NUM_ROWS = t_cfg_idx'(0);
    localparam t_cfg_idx REG_NUM_COLS = t_cfg_idx'(1);

    // Parent store write port
    typedef struct packed {
        logic  en;
        t_cell addr;
        t_cell data;
    } t_ram_wr;

    // Cell indices of one wall and its range flag
    typedef struct packed {
        t_cell idx_a;
        t_cell idx_b;
        logic  bad;
    } t_wall_idx;

    // Zero counts as one, anything above the limit as the limit
    function automatic t_side clamp_side(input t_side v);
        t_side res;
        res = v;
        if (v == '0) begin
            res = t_side'(1);
        end else if (int'(v) > MAX_SIDE) begin
            res = t_side'(MAX_SIDE);
        end
        return res;
    endfunction

    // Number of cells in use, limited to the store depth
    function automatic t_cnt cells_in_use(input t_side rows, input t_side cols);
        logic [PROD_W-1:0] prod;
        t_cnt              res;
        prod = PROD_W'(rows) * PROD_W'(cols);
        if (int'(prod) > MAX_CELLS) begin
            res = t_cnt'(MAX_CELLS);
        end else begin
            res = prod[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/mwuf_ifs.sv */
// ----------------------------------------------------------------------------
// mwuf_ifs
// Handshake channels of the maze wall filter: walls in, results out, config.
// ----------------------------------------------------------------------------
interface mwuf_item_if import mwuf_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   mode;
    t_coord row_a;
    t_coord col_a;
    t_coord row_b;
    t_coord col_b;

    modport source (output valid, mode, row_a, col_a, row_b, col_b, input ready);
    modport sink   (input valid, mode, row_a, col_a, row_b, col_b, output ready);
endinterface

interface mwuf_res_if;
    logic valid;
    logic ready;
    logic wall_stays;
    logic all_joined;
    logic bad_wall;

    modport source (output valid, wall_stays, all_joined, bad_wall, input ready);
    modport sink   (input valid, wall_stays, all_joined, bad_wall, output ready);
endinterface

interface mwuf_cfg_if import mwuf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_side    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mwuf_parent_ram.sv */
// ----------------------------------------------------------------------------
// mwuf_parent_ram
// Parent store of the disjoint-set forest: one write, one registered read.
// ----------------------------------------------------------------------------
module mwuf_parent_ram import mwuf_pkg::*; (
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_cell   i_rd_addr,
    output t_cell   o_rd_data
);

    t_cell mem [MAX_CELLS];
    t_cell r_rd_data;

    // Write and read; a read of the entry written in the same cycle returns its old value
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mwuf_index.sv */
// ----------------------------------------------------------------------------
// mwuf_index
// Range check of a wall's coordinates and row-major cell index calculation.
// ----------------------------------------------------------------------------
module mwuf_index import mwuf_pkg::*; (
    input  t_side     i_rows,
    input  t_side     i_cols,
    input  t_cnt      i_cells,
    input  t_coord    i_row_a,
    input  t_coord    i_col_a,
    input  t_coord    i_row_b,
    input  t_coord    i_col_b,
    output t_wall_idx o_wall
);

    logic [PROD_W-1:0] lin_a;
    logic [PROD_W-1:0] lin_b;
    logic              out_grid;
    logic              out_cells;

    // Coordinates against the clamped grid
    assign out_grid = (SIDE_W'(i_row_a) >= i_rows) || (SIDE_W'(i_row_b) >= i_rows) ||
                      (SIDE_W'(i_col_a) >= i_cols) || (SIDE_W'(i_col_b) >= i_cols);

    // index = column + row * columns
    assign lin_a = PROD_W'(i_row_a) * PROD_W'(i_cols) + PROD_W'(i_col_a);
    assign lin_b = PROD_W'(i_row_b) * PROD_W'(i_cols) + PROD_W'(i_col_b);

    assign out_cells = (lin_a >= PROD_W'(i_cells)) || (lin_b >= PROD_W'(i_cells));

    assign o_wall.idx_a = lin_a[CELL_W-1:0];
    assign o_wall.idx_b = lin_b[CELL_W-1:0];
    assign o_wall.bad   = out_grid || out_cells;

endmodule

/* rtl/maze_wall_union_find_filter.sv */
// ----------------------------------------------------------------------------
// maze_wall_union_find_filter
// Kruskal maze wall filter: union-find over grid cells held in a parent store.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  i_item    in    valid / ready    mode, row_a, col_a, row_b, col_b
//  o_res     out   valid / ready    wall_stays, all_joined, bad_wall
//  i_cfg     in    valid / ready    index (0 rows, 1 cols), data
//
//  A wall walks from cell a and from cell b up to their roots: every
//  step of the two root walks is one registered read of the parent store.
//  Path splitting on the walks keeps the trees shallow. A bad wall skips the walks.
//  A clear request, a config write and reset each sweep all MAX_CELLS entries,
//  one per cycle; no request is taken meanwhile, config is.
//  The result sits in an output register, so a stalled sink holds one result
//  while the next request may already be taken.
// ----------------------------------------------------------------------------
module maze_wall_union_find_filter import mwuf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwuf_item_if.sink  i_item,
    mwuf_res_if.source o_res,
    mwuf_cfg_if.sink   i_cfg
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_FIND_A = 5'b00100,
        S_FIND_B = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_side  r_rows, n_rows;
    t_side  r_cols, n_cols;
    t_cell  r_clr_addr, n_clr_addr;
    logic   r_clr_item, n_clr_item;
    t_cnt   r_sets_left, n_sets_left;
    logic   r_ov, n_ov;
    logic   r_prev_v, n_prev_v;

    t_cell  r_idx_b, n_idx_b;
    t_cell  r_cur, n_cur;
    t_cell  r_prev, n_prev;
    t_cell  r_root_a, n_root_a;
    logic   r_stays, n_stays;
    logic   r_bad, n_bad;
    logic   r_o_stays, n_o_stays;
    logic   r_o_joined, n_o_joined;
    logic   r_o_bad, n_o_bad;

    t_side     rows_c;
    t_side     cols_c;
    t_cnt      cells;
    t_wall_idx wall;
    t_ram_wr   ram_wr;
    t_cell     rd_addr;
    t_cell     rd_data;
    logic      root_hit;
    logic      item_fire;
    logic      cfg_hit;
    logic      out_free;

    // Grid size in use
    assign rows_c = clamp_side(r_rows);
    assign cols_c = clamp_side(r_cols);
    assign cells  = cells_in_use(rows_c, cols_c);

    mwuf_index u_index (
        .i_rows  (rows_c),
        .i_cols  (cols_c),
        .i_cells (cells),
        .i_row_a (i_item.row_a),
        .i_col_a (i_item.col_a),
        .i_row_b (i_item.row_b),
        .i_col_b (i_item.col_b),
        .o_wall  (wall)
    );

    mwuf_parent_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshakes; a request waits while a config write is offered
    assign i_item.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready  = 1'b1;
    assign item_fire    = i_item.valid && i_item.ready;
    assign cfg_hit      = i_cfg.valid &&
                          ((i_cfg.index == REG_NUM_ROWS) || (i_cfg.index == REG_NUM_COLS));
    assign out_free     = !r_ov || o_res.ready;

    // Entry read last cycle is its own parent: root found
    assign root_hit = (rd_data == r_cur);

    assign o_res.valid      = r_ov;
    assign o_res.wall_stays = r_o_stays;
    assign o_res.all_joined = r_o_joined;
    assign o_res.bad_wall   = r_o_bad;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_clr_addr  = r_clr_addr;
        n_clr_item  = r_clr_item;
        n_sets_left = r_sets_left;
        n_ov        = r_ov;
        n_prev_v    = r_prev_v;
        n_idx_b     = r_idx_b;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_root_a    = r_root_a;
        n_stays     = r_stays;
        n_bad       = r_bad;
        n_o_stays   = r_o_stays;
        n_o_joined  = r_o_joined;
        n_o_bad     = r_o_bad;
        ram_wr      = '0;
        rd_addr     = r_cur;

        // result taken by the sink
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_wr = '{en: 1'b1, addr: r_clr_addr, data: r_clr_addr};
                if (r_clr_addr == t_cell'(MAX_CELLS - 1)) begin
                    n_sets_left = cells;
                    n_stays     = 1'b0;
                    n_bad       = 1'b0;
                    n_state     = r_clr_item ? S_DONE : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + t_cell'(1);
                end
            end
            S_IDLE: begin
                if (item_fire) begin
                    if (!i_item.mode) begin
                        n_clr_addr = '0;
                        n_clr_item = 1'b1;
                        n_state    = S_CLEAR;
                    end else if (wall.bad) begin
                        n_stays = 1'b1;
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad    = 1'b0;
                        n_idx_b  = wall.idx_b;
                        n_cur    = wall.idx_a;
                        rd_addr  = wall.idx_a;
                        n_prev_v = 1'b0;
                        n_state  = S_FIND_A;
                    end
                end
            end
            S_FIND_A, S_FIND_B: begin
                if (root_hit) begin
                    if (r_state == S_FIND_A) begin
                        // start the walk from b
                        n_root_a = r_cur;
                        n_cur    = r_idx_b;
                        rd_addr  = r_idx_b;
                        n_prev_v = 1'b0;
                        n_state  = S_FIND_B;
                    end else begin
                        if (r_cur == r_root_a) begin
                            n_stays = 1'b1;
                        end else begin
                            // merge: b's root hangs under a's root
                            ram_wr  = '{en: 1'b1, addr: r_cur, data: r_root_a};
                            n_stays = 1'b0;
                            if (r_sets_left != '0) begin
                                n_sets_left = r_sets_left - t_cnt'(1);
                            end
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    // step up; previous node skips to its grandparent
                    if (r_prev_v) begin
                        ram_wr = '{en: 1'b1, addr: r_prev, data: rd_data};
                    end
                    n_prev   = r_cur;
                    n_prev_v = 1'b1;
                    n_cur    = rd_data;
                    rd_addr  = rd_data;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_stays  = r_stays;
                    n_o_joined = (r_sets_left == t_cnt'(1));
                    n_o_bad    = r_bad;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_clr_addr = '0;
                n_clr_item = 1'b0;
                n_state    = S_CLEAR;
            end
        endcase

        // Config write: new grid size and a fresh sweep
        if (cfg_hit) begin
            if (i_cfg.index == REG_NUM_ROWS) begin
                n_rows = i_cfg.data;
            end else begin
                n_cols = i_cfg.data;
            end
            n_clr_addr = '0;
            n_clr_item = (r_state == S_CLEAR) ? r_clr_item : 1'b0;
            n_state    = S_CLEAR;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rows      <= t_side'(MAX_SIDE);
            r_cols      <= t_side'(MAX_SIDE);
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_sets_left <= '0;
            r_ov        <= 1'b0;
            r_prev_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_clr_addr  <= n_clr_addr;
            r_clr_item  <= n_clr_item;
            r_sets_left <= n_sets_left;
            r_ov        <= n_ov;
            r_prev_v    <= n_prev_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx_b    <= n_idx_b;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_root_a   <= n_root_a;
        r_stays    <= n_stays;
        r_bad      <= n_bad;
        r_o_stays  <= n_o_stays;
        r_o_joined <= n_o_joined;
        r_o_bad    <= n_o_bad;
    end

endmodule
